// ----- rtl/ilid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ilid_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;
	localparam logic [2:0] OP_FILL   = 3'd5;
	localparam logic [2:0] OP_CLEAR  = 3'd6;
	localparam logic [2:0] OP_DEDUP  = 3'd7;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               operation;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0]         fill_count;
		logic [1:0]               status;
		logic                     is_empty;
	} rsp_t;

	// per-cell load select; priority val > left > right
	typedef struct packed {
		logic load_val;
		logic load_left;
		logic load_right;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/ilid_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ilid_cell (
	input  wire                               clk,
	input  wire ilid_pkg::cell_ctl_t          ctl,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] val,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] left,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] right,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] cand,
	output logic signed [ilid_pkg::DATA_W-1:0]      data,
	output logic                                    hit
);
	import ilid_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load_val) begin
			data_q <= val;
		end else if (ctl.load_left) begin
			data_q <= left;
		end else if (ctl.load_right) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	assign hit  = (data_q == cand);

endmodule
`default_nettype wire

// ----- rtl/indexed_list_insert_delete_dedup.sv -----
// Ordered list of signed 32-bit words held in a row of shifting cells.
// Request channel (req_valid/req_ready/req): operation, position, value.
// Response channel (rsp_valid/rsp_ready/rsp): read word, fill count,
// status and empty flag; exactly one response per request.
// Insert, append, delete, read, write, fill and clear finish at the
// accepting edge: the cells shift or load in parallel and the response is
// valid the next cycle. Remove-duplicates walks the list one entry at a time,
// first in a load state (fetch the candidate through the read mux), then in
// a check state (compare it against all kept cells at once); its response
// appears after the last entry is checked.
// The response sits in an output register; a new request is taken when the
// sequencer is idle and that register is empty or being read at the same
// edge, so requests other than remove-duplicates run back to back at one
// per cycle while the receiver reads; a stalled receiver with a response
// waiting holds req_ready low. Reset clears the fill count and the response
// valid flag; cell contents are undefined until written. Out-of-range positions
// and inserts or appends to a full list are ignored and reported in status.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_insert_delete_dedup #(
	parameter int DEPTH = ilid_pkg::DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  wire ilid_pkg::req_t req,
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output ilid_pkg::rsp_t  rsp
);
	import ilid_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOAD  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q, count_n;
	logic [CW-1:0] r_q, kept_q, kept_inc;
	logic          rsp_valid_q, rsp_set;
	logic signed [DATA_W-1:0] rd_q, rd_n, cand_q, rd_data, val_bus;
	logic [1:0]    status_q, status_n;

	logic [AW-1:0] pos_ext, count_ext, kept_ext, rd_addr;
	logic          accept, full, seen, dedup_last;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]         cell_hit;
	cell_ctl_t                cell_ctl [DEPTH];

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign pos_ext   = AW'(req.position);
	assign count_ext = AW'(count_q);
	assign kept_ext  = AW'(kept_q);
	assign full      = (count_q == CW'(DEPTH));
	assign val_bus   = (state_q == S_CHECK) ? cand_q : req.value;
	assign rd_addr   = (state_q == S_LOAD) ? AW'(r_q) : pos_ext;
	assign kept_inc  = seen ? kept_q : kept_q + CW'(1);
	assign dedup_last = ((r_q + CW'(1)) == count_q);

	// response register loads on a finished request
	assign rsp_set = (state_q == S_IDLE && accept
			&& !(req.operation == OP_DEDUP && count_q != '0))
		|| (state_q == S_CHECK && dedup_last);

	// read mux and duplicate search over the cell row
	always_comb begin
		rd_data = '0;
		seen    = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (AW'(i) == rd_addr) begin
				rd_data = rd_data | cell_data[i];
			end
			if (cell_hit[i] && (AW'(i) < kept_ext)) begin
				seen = 1'b1;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic signed [DATA_W-1:0] left_d, right_d;
			logic [AW-1:0]            idx;

			assign idx = AW'(g);

			if (g == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_mid_l
				assign left_d = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_mid_r
				assign right_d = cell_data[g+1];
			end

			always_comb begin
				cell_ctl[g] = '0;
				if (state_q == S_IDLE && accept) begin
					case (req.operation)
						OP_INSERT: begin
							if (pos_ext <= count_ext && !full) begin
								cell_ctl[g].load_val  = (idx == pos_ext);
								cell_ctl[g].load_left = (idx > pos_ext) && (idx <= count_ext);
							end
						end
						OP_APPEND: cell_ctl[g].load_val = !full && (idx == count_ext);
						OP_DELETE: begin
							if (pos_ext < count_ext) begin
								cell_ctl[g].load_right = (idx >= pos_ext)
									&& ((idx + AW'(1)) < count_ext);
							end
						end
						OP_WRITE:  cell_ctl[g].load_val = (pos_ext < count_ext) && (idx == pos_ext);
						OP_FILL:   cell_ctl[g].load_val = (idx < count_ext);
						default:   cell_ctl[g] = '0;
					endcase
				end else if (state_q == S_CHECK) begin
					cell_ctl[g].load_val = !seen && (idx == kept_ext);
				end
			end

			ilid_cell u_cell (
				.clk   (clk),
				.ctl   (cell_ctl[g]),
				.val   (val_bus),
				.left  (left_d),
				.right (right_d),
				.cand  (cand_q),
				.data  (cell_data[g]),
				.hit   (cell_hit[g])
			);
		end
	endgenerate

	// result and next count of a request completed at acceptance
	always_comb begin
		rd_n     = '0;
		status_n = ST_DONE;
		count_n  = count_q;
		case (req.operation)
			OP_INSERT: begin
				if (pos_ext > count_ext) begin
					status_n = ST_RANGE;
				end else if (full) begin
					status_n = ST_FULL;
				end else begin
					count_n = count_q + CW'(1);
				end
			end
			OP_APPEND: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					count_n = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (pos_ext >= count_ext) begin
					status_n = ST_RANGE;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (pos_ext >= count_ext) begin
					status_n = ST_RANGE;
				end else begin
					rd_n = rd_data;
				end
			end
			OP_WRITE: begin
				if (pos_ext >= count_ext) begin
					status_n = ST_RANGE;
				end
			end
			OP_CLEAR: count_n = '0;
			default:  count_n = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			r_q         <= '0;
			kept_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.operation == OP_DEDUP && count_q != '0) begin
							state_q <= S_LOAD;
							r_q     <= '0;
							kept_q  <= '0;
						end else begin
							count_q <= count_n;
						end
					end
				end
				S_LOAD: state_q <= S_CHECK;
				S_CHECK: begin
					kept_q <= kept_inc;
					if (dedup_last) begin
						count_q <= kept_inc;
						state_q <= S_IDLE;
					end else begin
						r_q     <= r_q + CW'(1);
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			cand_q <= rd_data;
		end
		if (state_q == S_IDLE && accept) begin
			rd_q     <= rd_n;
			status_q <= status_n;
		end else if (state_q == S_CHECK && dedup_last) begin
			rd_q     <= '0;
			status_q <= ST_DONE;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp.read_value  = rd_q;
	assign rsp.fill_count  = count_ext[POS_W-1:0];
	assign rsp.status      = status_q;
	assign rsp.is_empty    = (count_q == '0);

endmodule
`default_nettype wire

// ----- dv/indexed_list_insert_delete_dedup_tb.sv -----
`timescale 1ns / 1ps
module indexed_list_insert_delete_dedup_tb;
	import ilid_pkg::*;

	localparam int LIST_DEPTH    = DEPTH_DEF;
	localparam int ITEMS_PER_PHASE = 106;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_TAIL    = 2 * LIST_DEPTH + 8;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		req_t cmd;
		bit   pinned;
		rsp_t want;
	} stim_row_t;

	typedef struct {
		bit   pinned;
		rsp_t want;
	} pin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// list shadow
	logic signed [DATA_W-1:0] shadow_words [LIST_DEPTH];
	int shadow_fill = 0;

	rsp_t pending_rsps [$];
	pin_t pin_q [$];
	stim_row_t directed_rows [$];

	int error_count = 0;
	int accepted_count = 0;
	int checked_count = 0;
	int full_count = 0;
	int range_count = 0;
	int dedup_count = 0;
	int peak_fill = 0;
	int cycle_count = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	indexed_list_insert_delete_dedup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
				pending_rsps.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic rsp_t apply_list_request(req_t cmd);
		rsp_t res;
		int kept;
		bit seen;
		res = '0;
		res.status = ST_DONE;
		case (cmd.operation)
			OP_INSERT: begin
				if (cmd.position > shadow_fill) begin
					res.status = ST_RANGE;
				end else if (shadow_fill >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = shadow_fill; i > cmd.position; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[cmd.position] = cmd.value;
					shadow_fill++;
				end
			end
			OP_APPEND: begin
				if (shadow_fill >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_fill] = cmd.value;
					shadow_fill++;
				end
			end
			OP_DELETE: begin
				if (cmd.position >= shadow_fill) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = cmd.position; i + 1 < shadow_fill; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_fill--;
				end
			end
			OP_READ: begin
				if (cmd.position >= shadow_fill)
					res.status = ST_RANGE;
				else
					res.read_value = shadow_words[cmd.position];
			end
			OP_WRITE: begin
				if (cmd.position >= shadow_fill)
					res.status = ST_RANGE;
				else
					shadow_words[cmd.position] = cmd.value;
			end
			OP_FILL: begin
				for (int i = 0; i < shadow_fill; i++)
					shadow_words[i] = cmd.value;
			end
			OP_CLEAR: begin
				shadow_fill = 0;
			end
			default: begin
				// keep first occurrence of each word, compacted in order
				kept = 0;
				for (int r = 0; r < shadow_fill; r++) begin
					seen = 1'b0;
					for (int k = 0; k < kept; k++)
						if (shadow_words[k] == shadow_words[r])
							seen = 1'b1;
					if (!seen) begin
						shadow_words[kept] = shadow_words[r];
						kept++;
					end
				end
				shadow_fill = kept;
			end
		endcase
		res.fill_count = shadow_fill[POS_W-1:0];
		res.is_empty = (shadow_fill == 0);
		return res;
	endfunction

	function automatic void check_response(rsp_t got);
		rsp_t want;
		if (pending_rsps.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("Unexpected response: rd=%h cnt=%0d st=%0d empty=%0b",
					got.read_value, got.fill_count, got.status, got.is_empty);
			return;
		end
		want = pending_rsps.pop_front();
		checked_count++;
		if (got.read_value !== want.read_value || got.fill_count !== want.fill_count ||
				got.status !== want.status || got.is_empty !== want.is_empty) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("Mismatch on response %0d: exp rd=%h cnt=%0d st=%0d empty=%0b, got rd=%h cnt=%0d st=%0d empty=%0b",
					checked_count, want.read_value, want.fill_count, want.status,
					want.is_empty, got.read_value, got.fill_count, got.status,
					got.is_empty);
		end
	endfunction

	// scoreboard: response check before the new request's prediction
	rsp_t predicted;
	pin_t pin;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_response(rsp);
			if (req_valid && req_ready) begin
				predicted = apply_list_request(req);
				if (pin_q.size() != 0) begin
					pin = pin_q.pop_front();
					if (pin.pinned)
						predicted = pin.want;
				end
				pending_rsps.push_back(predicted);
				accepted_count++;
				if (predicted.status == ST_FULL)
					full_count++;
				if (predicted.status == ST_RANGE)
					range_count++;
				if (req.operation == OP_DEDUP)
					dedup_count++;
				if (shadow_fill > peak_fill)
					peak_fill = shadow_fill;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic stim_row_t make_row(logic [2:0] op, int pos, logic [31:0] val,
			bit pinned, logic [31:0] rd, int cnt, logic [1:0] st, bit empty);
		stim_row_t row;
		row.cmd.operation = op;
		row.cmd.position = pos[POS_W-1:0];
		row.cmd.value = val;
		row.pinned = pinned;
		row.want.read_value = rd;
		row.want.fill_count = cnt[POS_W-1:0];
		row.want.status = st;
		row.want.is_empty = empty;
		return row;
	endfunction

	function automatic req_t next_random_request(int grow_pct);
		req_t cmd;
		int pick;
		int span;
		cmd = '0;
		pick = $urandom_range(0, 99);
		if (pick < grow_pct) begin
			cmd.operation = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				cmd.operation = OP_DELETE;
			else if (pick < 50)
				cmd.operation = OP_READ;
			else if (pick < 72)
				cmd.operation = OP_WRITE;
			else if (pick < 80)
				cmd.operation = OP_FILL;
			else if (pick < 83)
				cmd.operation = OP_CLEAR;
			else if (pick < 90)
				cmd.operation = OP_DEDUP;
			else
				cmd.operation = OP_APPEND;
		end
		// mostly legal positions, some anywhere in the field
		if ($urandom_range(0, 99) < 85) begin
			span = (cmd.operation == OP_INSERT) ? shadow_fill : shadow_fill - 1;
			cmd.position = (span < 0) ? '0 : POS_W'($urandom_range(0, span));
		end else begin
			cmd.position = POS_W'($urandom_range(0, 127));
		end
		// small pool of words so dedup has something to remove
		if ($urandom_range(0, 99) < 40)
			cmd.value = int'($urandom_range(0, 7)) - 2;
		else
			cmd.value = $urandom;
		return cmd;
	endfunction

	task automatic send_one(req_t cmd, bit pinned, rsp_t want);
		int gap;
		pin_t entry;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry.pinned = pinned;
		entry.want = want;
		pin_q.push_back(entry);
		req <= cmd;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_rsps.size() != 0);
	endtask

	initial begin
		req_t cmd;
		directed_rows.push_back(make_row(OP_READ,   0,   32'h0, 1, 32'h0, 0, ST_RANGE, 1));
		directed_rows.push_back(make_row(OP_DELETE, 0,   32'h0, 1, 32'h0, 0, ST_RANGE, 1));
		directed_rows.push_back(make_row(OP_WRITE,  0,   32'h5, 1, 32'h0, 0, ST_RANGE, 1));
		directed_rows.push_back(make_row(OP_INSERT, 1,   32'h1, 1, 32'h0, 0, ST_RANGE, 1));
		directed_rows.push_back(make_row(OP_FILL,   3,   32'h9, 1, 32'h0, 0, ST_DONE, 1));
		directed_rows.push_back(make_row(OP_DEDUP,  5,   32'h0, 1, 32'h0, 0, ST_DONE, 1));
		directed_rows.push_back(make_row(OP_CLEAR,  0,   32'h0, 1, 32'h0, 0, ST_DONE, 1));
		directed_rows.push_back(make_row(OP_APPEND, 127, 32'h7FFF_FFFF, 1, 32'h0, 1,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_INSERT, 0,   32'h8000_0000, 1, 32'h0, 2,
			ST_DONE, 0));
		// insert at position == count is legal
		directed_rows.push_back(make_row(OP_INSERT, 2,   32'h0, 1, 32'h0, 3, ST_DONE, 0));
		directed_rows.push_back(make_row(OP_READ,   0,   32'h0, 1, 32'h8000_0000, 3,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_READ,   1,   32'h0, 1, 32'h7FFF_FFFF, 3,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_READ,   127, 32'h0, 1, 32'h0, 3, ST_RANGE, 0));
		directed_rows.push_back(make_row(OP_INSERT, 4,   32'h1, 1, 32'h0, 3, ST_RANGE, 0));
		directed_rows.push_back(make_row(OP_WRITE,  3,   32'h1, 1, 32'h0, 3, ST_RANGE, 0));
		directed_rows.push_back(make_row(OP_WRITE,  1,   32'hFFFF_FFFF, 1, 32'h0, 3,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_INSERT, 1,   32'h0, 0, 32'h0, 0, ST_DONE, 0));
		directed_rows.push_back(make_row(OP_APPEND, 64,  32'hFFFF_FFFF, 0, 32'h0, 0,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_DEDUP,  0,   32'h0, 1, 32'h0, 3, ST_DONE, 0));
		directed_rows.push_back(make_row(OP_READ,   2,   32'h0, 1, 32'hFFFF_FFFF, 3,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_DELETE, 0,   32'h0, 1, 32'h0, 2, ST_DONE, 0));
		directed_rows.push_back(make_row(OP_DELETE, 2,   32'h0, 1, 32'h0, 2, ST_RANGE, 0));
		directed_rows.push_back(make_row(OP_FILL,   64,  32'h5555_5555, 1, 32'h0, 2,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_READ,   1,   32'h0, 1, 32'h5555_5555, 2,
			ST_DONE, 0));
		directed_rows.push_back(make_row(OP_CLEAR,  127, 32'hAAAA_AAAA, 1, 32'h0, 0,
			ST_DONE, 1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_one(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver stall while requests keep coming
				if (phase == 0 && n == 60)
					hold_request = 150;
				case (phase)
					0: cmd = next_random_request(90);
					1: cmd = next_random_request(45);
					2: cmd = next_random_request(65);
					default: cmd = next_random_request(40);
				endcase
				send_one(cmd, 1'b0, '0);
			end
			if (phase == 1) begin
				req_valid <= 1'b0;
				wait_drained();
			end
		end
		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);

		if (pending_rsps.size() != 0) begin
			error_count += pending_rsps.size();
			$display("%0d expected responses never arrived", pending_rsps.size());
		end
		$display("Covered %0d requests, %0d responses checked, %0d failures", accepted_count,
			checked_count, error_count);
		$display("Rejected: %0d full, %0d out of range; %0d dedup passes; peak fill %0d",
			full_count, range_count, dedup_count, peak_fill);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
